// File: design/assert_macros.svh
// Assertion macros used by the checker file slu_checker.sv.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/slu_pkg.sv
// Shared types, character codes and helpers for the string literal unescaper.
// Depends on nothing; used by the interfaces and every module of the block.
`timescale 1ns / 1ps

package slu_pkg;

  typedef logic [31:0] char_t;
  typedef logic [3:0]  digit_cnt_t;

  localparam char_t CH_DQUOTE    = 32'h0000_0022;
  localparam char_t CH_SQUOTE    = 32'h0000_0027;
  localparam char_t CH_BACKSLASH = 32'h0000_005C;
  localparam char_t CH_LF        = 32'h0000_000A;
  localparam char_t CH_CR        = 32'h0000_000D;
  localparam char_t CH_TAB       = 32'h0000_0009;
  localparam char_t CH_FF        = 32'h0000_000C;

  localparam char_t ESC_N        = 32'h0000_006E;
  localparam char_t ESC_R        = 32'h0000_0072;
  localparam char_t ESC_T        = 32'h0000_0074;
  localparam char_t ESC_F        = 32'h0000_0066;
  localparam char_t ESC_AR_JEEM  = 32'h0000_062C;
  localparam char_t ESC_AR_RA    = 32'h0000_0631;
  localparam char_t ESC_AR_TA    = 32'h0000_062A;
  localparam char_t ESC_X        = 32'h0000_0078;
  localparam char_t ESC_H        = 32'h0000_0068;
  localparam char_t ESC_U_LOWER  = 32'h0000_0075;
  localparam char_t ESC_U_UPPER  = 32'h0000_0055;

  localparam digit_cnt_t HEX_LEN_BYTE = 4'd2;
  localparam digit_cnt_t HEX_LEN_U16  = 4'd4;
  localparam digit_cnt_t HEX_LEN_U32  = 4'd8;

  localparam logic CFG_OUTER_DQ_RESET = 1'b1;

  typedef struct packed {
    char_t character;
    logic  end_of_token;
  } item_t;

  typedef struct packed {
    char_t character_res;
    logic  has_character;
    logic  end_of_text;
  } result_t;

  function automatic logic [3:0] hex_value(input char_t c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 32'h30 && c <= 32'h39) begin
      v = c[3:0];
    end else if ((c >= 32'h41 && c <= 32'h46) || (c >= 32'h61 && c <= 32'h66)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

// File: design/slu_if.sv
// Channel interfaces of the string literal unescaper: token, text and config.
// Depends on slu_pkg for the character type.
`timescale 1ns / 1ps

interface slu_in_if;
  logic           valid;
  logic           ready;
  slu_pkg::char_t character;
  logic           end_of_token;
  modport source (output valid, character, end_of_token, input ready);
  modport sink   (input valid, character, end_of_token, output ready);
endinterface

interface slu_out_if;
  logic           valid;
  logic           ready;
  slu_pkg::char_t character_res;
  logic           has_character;
  logic           end_of_text;
  modport source (output valid, character_res, has_character, end_of_text, input ready);
  modport sink   (input valid, character_res, has_character, end_of_text, output ready);
endinterface

interface slu_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: design/slu_in_reg.sv
// Input register of the unescaper: captures one token beat per cycle unless the result register stalls.
// Depends on slu_pkg and slu_in_if.
`timescale 1ns / 1ps

module slu_in_reg (
  input  logic           clk,
  input  logic           rst,
  slu_in_if.sink         token,
  input  logic           advance,
  output logic           item_valid,
  output slu_pkg::item_t item
);

  logic accept;

  assign token.ready = !item_valid || advance;
  assign accept      = token.valid && token.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.character    <= token.character;
      item.end_of_token <= token.end_of_token;
    end
  end

endmodule

// File: design/slu_core.sv
// Scan state and escape decode of the unescaper: one character per step.
// Depends on slu_pkg.
`timescale 1ns / 1ps

module slu_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  slu_pkg::item_t   item,
  input  logic             take,
  input  logic             outer_dq,
  output logic             produce,
  output slu_pkg::result_t res
);

  typedef enum logic [1:0] {
    MODE_OUTSIDE,
    MODE_INSIDE,
    MODE_ESCAPE,
    MODE_HEX
  } mode_t;

  mode_t                 mode, mode_next;
  slu_pkg::digit_cnt_t   hex_left, hex_left_next, hex_left_dec;
  slu_pkg::char_t        hex_acc, hex_acc_next, hex_acc_shift;
  slu_pkg::char_t        outer, inner, c, val;
  logic                  emit;

  assign c             = item.character;
  assign outer         = outer_dq ? slu_pkg::CH_DQUOTE : slu_pkg::CH_SQUOTE;
  assign inner         = outer_dq ? slu_pkg::CH_SQUOTE : slu_pkg::CH_DQUOTE;
  assign hex_acc_shift = {hex_acc[27:0], slu_pkg::hex_value(c)};
  assign hex_left_dec  = (hex_left != '0) ? 4'(hex_left - 4'd1) : hex_left;

  always_comb begin
    mode_next     = mode;
    hex_left_next = hex_left;
    hex_acc_next  = hex_acc;
    emit          = 1'b0;
    val           = '0;
    unique case (mode)
      MODE_OUTSIDE: begin
        if (c == outer) mode_next = MODE_INSIDE;
      end
      MODE_INSIDE: begin
        priority if (c == outer) begin
          mode_next = MODE_OUTSIDE;
        end else if (c == slu_pkg::CH_BACKSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          emit = 1'b1;
          val  = c;
        end
      end
      MODE_ESCAPE: begin
        mode_next = MODE_INSIDE;
        priority if (c == outer || c == inner || c == slu_pkg::CH_BACKSLASH) begin
          emit = 1'b1;
          val  = c;
        end else if (c == slu_pkg::ESC_N || c == slu_pkg::ESC_AR_JEEM) begin
          emit = 1'b1;
          val  = slu_pkg::CH_LF;
        end else if (c == slu_pkg::ESC_R || c == slu_pkg::ESC_AR_RA) begin
          emit = 1'b1;
          val  = slu_pkg::CH_CR;
        end else if (c == slu_pkg::ESC_T || c == slu_pkg::ESC_AR_TA) begin
          emit = 1'b1;
          val  = slu_pkg::CH_TAB;
        end else if (c == slu_pkg::ESC_F) begin
          emit = 1'b1;
          val  = slu_pkg::CH_FF;
        end else if (c == slu_pkg::ESC_X || c == slu_pkg::ESC_H) begin
          mode_next     = MODE_HEX;
          hex_left_next = slu_pkg::HEX_LEN_BYTE;
          hex_acc_next  = '0;
        end else if (c == slu_pkg::ESC_U_LOWER) begin
          mode_next     = MODE_HEX;
          hex_left_next = slu_pkg::HEX_LEN_U16;
          hex_acc_next  = '0;
        end else if (c == slu_pkg::ESC_U_UPPER) begin
          mode_next     = MODE_HEX;
          hex_left_next = slu_pkg::HEX_LEN_U32;
          hex_acc_next  = '0;
        end else begin
          emit = 1'b0;
        end
      end
      MODE_HEX: begin
        hex_acc_next  = hex_acc_shift;
        hex_left_next = hex_left_dec;
        if (hex_left_dec == '0) begin
          emit         = 1'b1;
          val          = hex_acc_shift;
          mode_next    = MODE_INSIDE;
          hex_acc_next = '0;
        end
      end
      default: mode_next = MODE_OUTSIDE;
    endcase
    if (item.end_of_token) begin
      mode_next     = MODE_OUTSIDE;
      hex_left_next = '0;
      hex_acc_next  = '0;
    end
  end

  assign produce           = item_valid && (emit || item.end_of_token);
  assign res.character_res = val;
  assign res.has_character = emit;
  assign res.end_of_text   = item.end_of_token;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_OUTSIDE;
      hex_left <= '0;
      hex_acc  <= '0;
    end else if (take) begin
      mode     <= mode_next;
      hex_left <= hex_left_next;
      hex_acc  <= hex_acc_next;
    end
  end

endmodule

// File: design/slu_out_reg.sv
// Result register of the unescaper: holds one text beat until it is taken.
// Depends on slu_pkg and slu_out_if.
`timescale 1ns / 1ps

module slu_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  slu_pkg::result_t res,
  slu_out_if.source        text,
  output logic             can_load
);

  assign can_load = !text.valid || text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
    end else if (can_load) begin
      text.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      text.character_res <= res.character_res;
      text.has_character <= res.has_character;
      text.end_of_text   <= res.end_of_text;
    end
  end

endmodule

// File: design/string_literal_unescaper.sv
// String literal unescaper, top level.
// Depends on slu_pkg, slu_if, slu_in_reg, slu_core and slu_out_reg.
//
// Usage:
//   token: one UTF-32 character of a quoted literal per beat, end_of_token
//   on the last one. text: decoded characters; a beat carries a character
//   (has_character), the end marker (end_of_text) or both. Characters that
//   decode to nothing (outer quotes, escaping backslashes, hex digits before
//   the last, anything outside quotes) produce no text beat.
//   cfg: one-bit write, selects the double (1) or single (0) quote as the
//   outer delimiter. Write only while no token beat is in flight; it is
//   always ready.
//   A token beat passes the input register and then the result register.
//   Throughput: one token beat per cycle while text does not stall, set by
//   the scan state update between the input and result registers.
//   Reset: clears the valid bits of both registers and the scan state; outer quote is double.
//   When text stalls the result register holds its beat and the input
//   register takes at most one more beat before token.ready drops.
`timescale 1ns / 1ps

module string_literal_unescaper (
  input  logic      clk,
  input  logic      rst,
  slu_in_if.sink    token,
  slu_out_if.source text,
  slu_cfg_if.sink   cfg
);

  logic             item_valid, advance, can_load, produce, outer_dq;
  slu_pkg::item_t   item;
  slu_pkg::result_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_dq <= slu_pkg::CFG_OUTER_DQ_RESET;
    end else if (cfg.valid && cfg.ready) begin
      outer_dq <= cfg.data;
    end
  end

  assign advance = item_valid && can_load;

  slu_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .token      (token),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  slu_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (advance),
    .outer_dq   (outer_dq),
    .produce    (produce),
    .res        (res)
  );

  slu_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (produce),
    .res      (res),
    .text     (text),
    .can_load (can_load)
  );

endmodule

// File: design/slu_checker.sv
// Port-level checks for the string literal unescaper, bound to the top level.
// Depends on slu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slu_checker (
  input logic           clk,
  input logic           rst,
  input logic           tok_ready,
  input logic           txt_valid,
  input logic           txt_ready,
  input slu_pkg::char_t character_res,
  input logic           has_character,
  input logic           end_of_text
);

  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, ($past(rst) && !rst) |-> (tok_ready && !txt_valid), "not idle after reset")
  `ASSERT_CLK(a_beat_content, clk, rst, txt_valid |-> (has_character || end_of_text), "empty text beat")
  `ASSERT_CLK(a_zero_char, clk, rst, (txt_valid && !has_character) |-> (character_res == '0), "stray character")
  `ASSERT_CLK(a_stall_hold, clk, rst, (txt_valid && !txt_ready) |=> (txt_valid && $stable({character_res, has_character, end_of_text})), "text beat changed under stall")

endmodule

bind string_literal_unescaper slu_checker u_slu_checker (
  .clk           (clk),
  .rst           (rst),
  .tok_ready     (token.ready),
  .txt_valid     (text.valid),
  .txt_ready     (text.ready),
  .character_res (text.character_res),
  .has_character (text.has_character),
  .end_of_text   (text.end_of_text)
);

// File: test/unescape_checker.sv
// Observes the token, text and config channels of the string literal unescaper,
// predicts each text beat and compares it. Depends on slu_pkg and slu_if.
`timescale 1ns / 1ps

module unescape_checker
  import slu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  slu_in_if           token,
  slu_out_if          text,
  slu_cfg_if          cfg,
  output int unsigned fail_count,
  output int unsigned due_count
);

  typedef enum logic [1:0] {
    SCAN_OUTSIDE,
    SCAN_INSIDE,
    SCAN_ESCAPE,
    SCAN_HEX
  } scan_e;

  logic       outer_dq;
  scan_e      mode;
  digit_cnt_t digits_left;
  char_t      acc;
  result_t    text_due[$];
  result_t    want;

  function automatic logic [3:0] nibble_of(input char_t c);
    if (c >= 32'h30 && c <= 32'h39) return c[3:0];
    if (c >= 32'h41 && c <= 32'h46) return 4'(c - 32'h37);
    if (c >= 32'h61 && c <= 32'h66) return 4'(c - 32'h57);
    return 4'd0;
  endfunction

  function automatic void decode_char(input char_t c, input logic last);
    char_t   outer;
    char_t   inner;
    char_t   val;
    logic    emit;
    result_t r;
    outer = outer_dq ? CH_DQUOTE : CH_SQUOTE;
    inner = outer_dq ? CH_SQUOTE : CH_DQUOTE;
    emit  = 1'b0;
    val   = '0;
    case (mode)
      SCAN_OUTSIDE: begin
        if (c == outer) mode = SCAN_INSIDE;
      end
      SCAN_INSIDE: begin
        if (c == outer) begin
          mode = SCAN_OUTSIDE;
        end else if (c == CH_BACKSLASH) begin
          mode = SCAN_ESCAPE;
        end else begin
          emit = 1'b1;
          val  = c;
        end
      end
      SCAN_ESCAPE: begin
        mode = SCAN_INSIDE;
        emit = 1'b1;
        if (c == outer || c == inner || c == CH_BACKSLASH) begin
          val = c;
        end else if (c == ESC_N || c == ESC_AR_JEEM) begin
          val = CH_LF;
        end else if (c == ESC_R || c == ESC_AR_RA) begin
          val = CH_CR;
        end else if (c == ESC_T || c == ESC_AR_TA) begin
          val = CH_TAB;
        end else if (c == ESC_F) begin
          val = CH_FF;
        end else begin
          emit = 1'b0;
          acc  = '0;
          if (c == ESC_X || c == ESC_H) begin
            mode        = SCAN_HEX;
            digits_left = HEX_LEN_BYTE;
          end else if (c == ESC_U_LOWER) begin
            mode        = SCAN_HEX;
            digits_left = HEX_LEN_U16;
          end else if (c == ESC_U_UPPER) begin
            mode        = SCAN_HEX;
            digits_left = HEX_LEN_U32;
          end
        end
      end
      default: begin
        acc = {acc[27:0], nibble_of(c)};
        if (digits_left != 0) digits_left = digits_left - 1'b1;
        if (digits_left == 0) begin
          emit = 1'b1;
          val  = acc;
          mode = SCAN_INSIDE;
          acc  = '0;
        end
      end
    endcase
    if (last) begin
      mode        = SCAN_OUTSIDE;
      digits_left = '0;
      acc         = '0;
    end
    if (emit || last) begin
      r.character_res = emit ? val : '0;
      r.has_character = emit;
      r.end_of_text   = last;
      text_due.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      outer_dq    = CFG_OUTER_DQ_RESET;
      mode        = SCAN_OUTSIDE;
      digits_left = '0;
      acc         = '0;
      text_due.delete();
      fail_count  = 0;
    end else begin
      if (text.valid && text.ready) begin
        if (text_due.size() == 0) begin
          $error("unexpected text beat: character_res %h has_character %b end_of_text %b",
                 text.character_res, text.has_character, text.end_of_text);
          fail_count++;
        end else begin
          want = text_due.pop_front();
          if (text.character_res !== want.character_res) begin
            $error("character_res: expected %h, got %h", want.character_res,
                   text.character_res);
            fail_count++;
          end
          if (text.has_character !== want.has_character) begin
            $error("has_character: expected %b, got %b", want.has_character,
                   text.has_character);
            fail_count++;
          end
          if (text.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %b, got %b", want.end_of_text, text.end_of_text);
            fail_count++;
          end
        end
      end
      if (token.valid && token.ready) decode_char(token.character, token.end_of_token);
      if (cfg.valid && cfg.ready) outer_dq = cfg.data;
    end
    due_count <= text_due.size();
  end

endmodule

// File: test/tb_string_literal_unescaper.sv
// Top of the string literal unescaper bench: clock, reset, token and config stimulus, text
// back-pressure and verdict. Depends on slu_pkg, slu_if, the DUT and unescape_checker.
`timescale 1ns / 1ps

module tb_string_literal_unescaper;
  import slu_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 285;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        calm = 1'b0;
  logic        outer_dq = CFG_OUTER_DQ_RESET;
  item_t       burst[$];
  int unsigned sent = 0;
  int unsigned quiet = 0;
  int unsigned fail_count;
  int unsigned due_count;

  slu_in_if  token ();
  slu_out_if text ();
  slu_cfg_if cfg ();

  string_literal_unescaper u_dut (
    .clk   (clk),
    .rst   (rst),
    .token (token),
    .text  (text),
    .cfg   (cfg)
  );

  unescape_checker u_unescape_chk (
    .clk        (clk),
    .rst        (rst),
    .token      (token),
    .text       (text),
    .cfg        (cfg),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    text.ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    if (rst || (token.valid && token.ready) || (text.valid && text.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[string_literal_unescaper] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic char_t quote_outer();
    return outer_dq ? CH_DQUOTE : CH_SQUOTE;
  endfunction

  function automatic char_t quote_inner();
    return outer_dq ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  function automatic void put(input char_t c);
    burst.push_back('{character: c, end_of_token: 1'b0});
  endfunction

  function automatic char_t plain_char();
    int unsigned pick;
    char_t       c;
    pick = $urandom_range(0, 99);
    if (pick < 20) return $urandom();
    if (pick < 30) return char_t'($urandom_range(32'h600, 32'h6FF));
    do begin
      c = $urandom_range(32'h20, 32'h7E);
    end while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic char_t hex_digit();
    int unsigned k;
    if ($urandom_range(0, 9) == 0) return $urandom();
    k = $urandom_range(0, 21);
    if (k < 10) return 32'h30 + k;
    if (k < 16) return 32'h61 + k - 10;
    return 32'h41 + k - 16;
  endfunction

  function automatic char_t simple_escape();
    case ($urandom_range(0, 9))
      0:       return quote_outer();
      1:       return quote_inner();
      2:       return CH_BACKSLASH;
      3:       return ESC_N;
      4:       return ESC_R;
      5:       return ESC_T;
      6:       return ESC_F;
      7:       return ESC_AR_JEEM;
      8:       return ESC_AR_RA;
      default: return ESC_AR_TA;
    endcase
  endfunction

  function automatic void add_piece();
    int unsigned pick;
    digit_cnt_t  len;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      put(plain_char());
    end else if (pick < 70) begin
      put(CH_BACKSLASH);
      put(simple_escape());
    end else if (pick < 85) begin
      put(CH_BACKSLASH);
      case ($urandom_range(0, 3))
        0: begin
          put(ESC_X);
          len = HEX_LEN_BYTE;
        end
        1: begin
          put(ESC_H);
          len = HEX_LEN_BYTE;
        end
        2: begin
          put(ESC_U_LOWER);
          len = HEX_LEN_U16;
        end
        default: begin
          put(ESC_U_UPPER);
          len = HEX_LEN_U32;
        end
      endcase
      repeat (len) put(hex_digit());
    end else if (pick < 90) begin
      put(CH_BACKSLASH);
      put($urandom());
    end else if (pick < 95) begin
      put(quote_inner());
    end else begin
      put(quote_outer());
      if ($urandom_range(0, 1) == 0) put(plain_char());
      put(quote_outer());
    end
  endfunction

  function automatic void build_token();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       put(CH_BACKSLASH);
          1:       put(quote_outer());
          default: put($urandom());
        endcase
      end
    end else begin
      if ($urandom_range(0, 6) == 0) put(plain_char());
      put(quote_outer());
      repeat ($urandom_range(1, 10)) add_piece();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        put(quote_outer());
      end else if (pick < 80) begin
        put(CH_BACKSLASH);
      end else if (pick < 90) begin
        put(CH_BACKSLASH);
        put(ESC_U_UPPER);
        repeat ($urandom_range(0, 7)) put(hex_digit());
      end
      if ($urandom_range(0, 9) == 0) put(plain_char());
    end
  endfunction

  task automatic push_char(input item_t it);
    if (!calm && $urandom_range(0, 99) < 8) begin
      token.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    token.valid        <= 1'b1;
    token.character    <= it.character;
    token.end_of_token <= it.end_of_token;
    @(posedge clk);
    while (!token.ready) @(posedge clk);
  endtask

  task automatic play_burst();
    burst[burst.size() - 1].end_of_token = 1'b1;
    foreach (burst[i]) push_char(burst[i]);
    sent += burst.size();
    burst.delete();
  endtask

  task automatic set_quote(input logic dq);
    token.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= dq;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    outer_dq = dq;
  endtask

  initial begin
    int          phase;
    int unsigned target;
    token.valid        <= 1'b0;
    token.character    <= '0;
    token.end_of_token <= 1'b0;
    cfg.valid          <= 1'b0;
    cfg.data           <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    put(32'h71);
    put(CH_DQUOTE);
    put(32'hFFFF_FFFF);
    put(32'h0000_0000);
    put(CH_SQUOTE);
    put(CH_BACKSLASH);
    put(32'h7A);
    put(CH_BACKSLASH);
    put(ESC_X);
    put(32'h34);
    put(32'h67);
    put(CH_BACKSLASH);
    put(ESC_AR_JEEM);
    put(CH_DQUOTE);
    put(CH_DQUOTE);
    put(CH_BACKSLASH);
    put(ESC_U_UPPER);
    put(32'h30);
    put(32'h30);
    put(32'h30);
    put(32'h31);
    put(32'h46);
    put(32'h36);
    put(32'h30);
    put(32'h61);
    play_burst();
    put(CH_DQUOTE);
    put(CH_BACKSLASH);
    put(ESC_U_LOWER);
    put(32'h31);
    play_burst();
    put(CH_DQUOTE);
    put(32'h61);
    play_burst();

    for (phase = 0; phase < 6; phase++) begin
      set_quote(phase % 2 == 1);
      calm   = (phase == 3);
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        build_token();
        play_burst();
      end
    end
    calm = 1'b0;

    token.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("[string_literal_unescaper] OK");
    end else begin
      $display("[string_literal_unescaper] ERROR");
    end
    $finish;
  end

endmodule
